>>> rtl/wmtk_pkg.sv
`default_nettype none

package wmtk_pkg;

   localparam int SCORE_BITS = 4;
   localparam int COORD_BITS = 32;
   localparam int CODE_BITS = 8;
   localparam int QUERY_CODE_BITS = 7;
   localparam int KEEP_BITS = 5;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam int OUT_ROW_BITS = 32;

   typedef logic [SCORE_BITS-1:0] score_type;
   typedef logic [CSR_INDEX_BITS-1:0] csr_index_type;

   localparam csr_index_type CSR_QUERY_REGION = 3'd0;
   localparam csr_index_type CSR_QUERY_CATEGORY = 3'd1;
   localparam csr_index_type CSR_QUERY_LATITUDE = 3'd2;
   localparam csr_index_type CSR_QUERY_LONGITUDE = 3'd3;
   localparam csr_index_type CSR_KEEP_COUNT = 3'd4;

   localparam logic [KEEP_BITS-1:0] KEEP_COUNT_RESET = 5'd5;

   localparam score_type SCORE_REGION = 4'd4;
   localparam score_type SCORE_CATEGORY = 4'd6;
   localparam score_type SCORE_NEAR = 4'd2;
   localparam score_type SCORE_MID = 4'd1;

   localparam logic [63:0] NEAR_LIMIT = 64'd17592186044;
   localparam logic [63:0] MID_LIMIT = 64'd175921860444;

   typedef struct packed {
      logic insert;
      logic shift_out;
      logic clear;
   } cell_cmd_type;

endpackage

`default_nettype wire

>>> rtl/wmtk_score.sv
`default_nettype none

module wmtk_score #(
   parameter int ROW_NUMBER_BITS = 32
) (
   input  wire logic                                       clock,
   input  wire logic                                       reset,
   input  wire logic                                       in_valid,
   input  wire logic signed [wmtk_pkg::CODE_BITS-1:0]      row_region,
   input  wire logic signed [wmtk_pkg::CODE_BITS-1:0]      row_category,
   input  wire logic signed [wmtk_pkg::COORD_BITS-1:0]     row_latitude,
   input  wire logic signed [wmtk_pkg::COORD_BITS-1:0]     row_longitude,
   input  wire logic [ROW_NUMBER_BITS-1:0]                 row_index,
   input  wire logic                                       final_row,
   input  wire logic [wmtk_pkg::QUERY_CODE_BITS-1:0]       query_region,
   input  wire logic [wmtk_pkg::QUERY_CODE_BITS-1:0]       query_category,
   input  wire logic signed [wmtk_pkg::COORD_BITS-1:0]     query_latitude,
   input  wire logic signed [wmtk_pkg::COORD_BITS-1:0]     query_longitude,
   output logic                                            out_valid,
   output wmtk_pkg::score_type                             out_score,
   output logic [ROW_NUMBER_BITS-1:0]                      out_row,
   output logic                                            out_final
);

   localparam int CB = wmtk_pkg::COORD_BITS;

   logic signed [CB:0] lat_diff;
   logic signed [CB:0] lon_diff;
   logic [CB:0] lat_mag;
   logic [CB:0] lon_mag;

   logic s1_valid_ff, s1_valid_in;
   logic s1_final_ff;
   logic [ROW_NUMBER_BITS-1:0] s1_row_ff;
   logic s1_region_ff, s1_category_ff, s1_dist_en_ff;
   logic s1_lat_over_ff, s1_lon_over_ff;
   logic [CB-1:0] s1_lat_mag_ff, s1_lon_mag_ff;

   logic s2_valid_ff;
   logic s2_final_ff;
   logic [ROW_NUMBER_BITS-1:0] s2_row_ff;
   logic s2_region_ff, s2_category_ff, s2_dist_en_ff;
   logic [63:0] s2_lat_sq_ff, s2_lon_sq_ff;
   logic [63:0] lat_sq_in, lon_sq_in;

   logic [64:0] dist_sum;
   logic [63:0] dist_sat;
   wmtk_pkg::score_type score_in;

   logic s3_valid_ff;
   logic s3_final_ff;
   logic [ROW_NUMBER_BITS-1:0] s3_row_ff;
   wmtk_pkg::score_type s3_score_ff;

   assign s1_valid_in = in_valid;
   assign lat_diff = (CB+1)'(row_latitude) - (CB+1)'(query_latitude);
   assign lon_diff = (CB+1)'(row_longitude) - (CB+1)'(query_longitude);
   assign lat_mag = lat_diff[CB] ? (CB+1)'(-lat_diff) : (CB+1)'(lat_diff);
   assign lon_mag = lon_diff[CB] ? (CB+1)'(-lon_diff) : (CB+1)'(lon_diff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_final_ff <= final_row;
      s1_row_ff <= row_index;
      s1_region_ff <= (query_region != '0) &&
                      (row_region == $signed({1'b0, query_region}));
      s1_category_ff <= (query_category != '0) &&
                        (row_category == $signed({1'b0, query_category}));
      s1_dist_en_ff <= (query_latitude != '0) && (query_longitude != '0) &&
                       (row_latitude != '0);
      s1_lat_over_ff <= lat_mag[CB];
      s1_lon_over_ff <= lon_mag[CB];
      s1_lat_mag_ff <= lat_mag[CB-1:0];
      s1_lon_mag_ff <= lon_mag[CB-1:0];
   end

   assign lat_sq_in = s1_lat_over_ff ? '1 : 64'(s1_lat_mag_ff) * 64'(s1_lat_mag_ff);
   assign lon_sq_in = s1_lon_over_ff ? '1 : 64'(s1_lon_mag_ff) * 64'(s1_lon_mag_ff);

   always_ff @(posedge clock) begin
      s2_final_ff <= s1_final_ff;
      s2_row_ff <= s1_row_ff;
      s2_region_ff <= s1_region_ff;
      s2_category_ff <= s1_category_ff;
      s2_dist_en_ff <= s1_dist_en_ff;
      s2_lat_sq_ff <= lat_sq_in;
      s2_lon_sq_ff <= lon_sq_in;
   end

   assign dist_sum = 65'(s2_lat_sq_ff) + 65'(s2_lon_sq_ff);
   assign dist_sat = dist_sum[64] ? '1 : dist_sum[63:0];

   always_comb begin
      score_in = '0;
      if (s2_region_ff) begin
         score_in = score_in + wmtk_pkg::SCORE_REGION;
      end
      if (s2_category_ff) begin
         score_in = score_in + wmtk_pkg::SCORE_CATEGORY;
      end
      if (s2_dist_en_ff) begin
         if (dist_sat <= wmtk_pkg::NEAR_LIMIT) begin
            score_in = score_in + wmtk_pkg::SCORE_NEAR;
         end else if (dist_sat <= wmtk_pkg::MID_LIMIT) begin
            score_in = score_in + wmtk_pkg::SCORE_MID;
         end
      end
   end

   always_ff @(posedge clock) begin
      s3_final_ff <= s2_final_ff;
      s3_row_ff <= s2_row_ff;
      s3_score_ff <= score_in;
   end

   assign out_valid = s3_valid_ff;
   assign out_score = s3_score_ff;
   assign out_row = s3_row_ff;
   assign out_final = s3_final_ff;

endmodule

`default_nettype wire

>>> rtl/wmtk_cell.sv
`default_nettype none

module wmtk_cell #(
   parameter int ROW_NUMBER_BITS = 32
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire wmtk_pkg::cell_cmd_type        cmd,
   input  wire wmtk_pkg::score_type           new_score,
   input  wire logic [ROW_NUMBER_BITS-1:0]    new_row,
   input  wire wmtk_pkg::score_type           prev_score,
   input  wire logic [ROW_NUMBER_BITS-1:0]    prev_row,
   input  wire logic                          prev_gt,
   input  wire wmtk_pkg::score_type           next_score,
   input  wire logic [ROW_NUMBER_BITS-1:0]    next_row,
   output logic                               gt,
   output wmtk_pkg::score_type                score,
   output logic [ROW_NUMBER_BITS-1:0]         row
);

   wmtk_pkg::score_type score_ff, score_in;
   logic [ROW_NUMBER_BITS-1:0] row_ff, row_in;

   // A new entry goes after every held entry of equal score.
   assign gt = cmd.insert && (new_score > score_ff);

   always_comb begin
      score_in = score_ff;
      row_in = row_ff;
      if (cmd.clear) begin
         score_in = '0;
      end else if (cmd.shift_out) begin
         score_in = next_score;
         row_in = next_row;
      end else if (gt) begin
         if (prev_gt) begin
            score_in = prev_score;
            row_in = prev_row;
         end else begin
            score_in = new_score;
            row_in = new_row;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         score_ff <= '0;
      end else begin
         score_ff <= score_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff <= row_in;
   end

   assign score = score_ff;
   assign row = row_ff;

endmodule

`default_nettype wire

>>> rtl/weighted_match_top_k_core.sv
// Scores a stream of rows against a query and keeps the best rows in a sorted list.
// Requests enter on start while busy is low, one row per cycle, each with its
// region, category, latitude, longitude and a final_row flag.
// Rows are numbered from 0 in arrival order; the numbering restarts after a final row.
// A row is scored in the register stages s1, s2 and s3 and then enters the list.
// The list is a chain of LIST_DEPTH cells that all take an insertion in the same cycle.
// Accepting a final row raises busy, which holds until the report is done.
// The first result is shown once the final row has been scored and has entered the list.
// Then one result follows each cycle, best score first, earlier rows first on ties.
// The report holds min(keep_count, LIST_DEPTH, held rows) results; rsp_last_result marks the last.
// Each result is shown for one cycle with rsp_strobe and is never held back.
// Busy falls once the report is done: after the last result, or once the final row is scored
// when nothing is reported; the list is then empty again.
// The user must write query registers on the csr_ port while the block is idle (not enforced).
// Reset empties the list, zeroes the row count and loads the register reset values.
`default_nettype none

module weighted_match_top_k_core #(
   parameter int LIST_DEPTH = 16,
   parameter int ROW_NUMBER_BITS = 32
) (
   input  wire logic                                       clock,
   input  wire logic                                       reset,
   input  wire logic                                       start,
   output logic                                            busy,
   input  wire logic signed [wmtk_pkg::CODE_BITS-1:0]      req_row_region,
   input  wire logic signed [wmtk_pkg::CODE_BITS-1:0]      req_row_category,
   input  wire logic signed [wmtk_pkg::COORD_BITS-1:0]     req_row_latitude,
   input  wire logic signed [wmtk_pkg::COORD_BITS-1:0]     req_row_longitude,
   input  wire logic                                       req_final_row,
   output logic                                            rsp_strobe,
   output logic [wmtk_pkg::OUT_ROW_BITS-1:0]               rsp_row_number,
   output logic [wmtk_pkg::SCORE_BITS-1:0]                 rsp_score_halves,
   output logic                                            rsp_last_result,
   input  wire logic                                       csr_write_enable,
   input  wire wmtk_pkg::csr_index_type                    csr_index,
   input  wire logic [wmtk_pkg::CSR_DATA_BITS-1:0]         csr_write_data
);

   logic accept;
   logic busy_ff, busy_in;
   logic emit_ff, emit_in;
   logic [wmtk_pkg::KEEP_BITS-1:0] emitted_ff, emitted_in;
   logic [ROW_NUMBER_BITS-1:0] rows_seen_ff, rows_seen_in;

   logic [wmtk_pkg::QUERY_CODE_BITS-1:0] query_region_ff, query_category_ff;
   logic signed [wmtk_pkg::COORD_BITS-1:0] query_latitude_ff, query_longitude_ff;
   logic [wmtk_pkg::KEEP_BITS-1:0] keep_count_ff;

   logic sc_valid, sc_final;
   wmtk_pkg::score_type sc_score;
   logic [ROW_NUMBER_BITS-1:0] sc_row;

   wmtk_pkg::cell_cmd_type cmd;
   wmtk_pkg::score_type cell_score [LIST_DEPTH];
   logic [ROW_NUMBER_BITS-1:0] cell_row [LIST_DEPTH];
   logic cell_gt [LIST_DEPTH];
   wmtk_pkg::score_type second_score;
   logic done;

   assign accept = start && !busy_ff;
   assign busy = busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         query_region_ff <= '0;
         query_category_ff <= '0;
         query_latitude_ff <= '0;
         query_longitude_ff <= '0;
         keep_count_ff <= wmtk_pkg::KEEP_COUNT_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            wmtk_pkg::CSR_QUERY_REGION: begin
               query_region_ff <= csr_write_data[wmtk_pkg::QUERY_CODE_BITS-1:0];
            end
            wmtk_pkg::CSR_QUERY_CATEGORY: begin
               query_category_ff <= csr_write_data[wmtk_pkg::QUERY_CODE_BITS-1:0];
            end
            wmtk_pkg::CSR_QUERY_LATITUDE: begin
               query_latitude_ff <= csr_write_data[wmtk_pkg::COORD_BITS-1:0];
            end
            wmtk_pkg::CSR_QUERY_LONGITUDE: begin
               query_longitude_ff <= csr_write_data[wmtk_pkg::COORD_BITS-1:0];
            end
            wmtk_pkg::CSR_KEEP_COUNT: begin
               keep_count_ff <= csr_write_data[wmtk_pkg::KEEP_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   wmtk_score #(
      .ROW_NUMBER_BITS(ROW_NUMBER_BITS)
   ) u_score (
      .clock(clock),
      .reset(reset),
      .in_valid(accept),
      .row_region(req_row_region),
      .row_category(req_row_category),
      .row_latitude(req_row_latitude),
      .row_longitude(req_row_longitude),
      .row_index(rows_seen_ff),
      .final_row(req_final_row),
      .query_region(query_region_ff),
      .query_category(query_category_ff),
      .query_latitude(query_latitude_ff),
      .query_longitude(query_longitude_ff),
      .out_valid(sc_valid),
      .out_score(sc_score),
      .out_row(sc_row),
      .out_final(sc_final)
   );

   assign rsp_strobe = emit_ff && (cell_score[0] != '0) && (emitted_ff != keep_count_ff);
   assign done = emit_ff && !rsp_strobe;

   always_comb begin
      cmd.insert = sc_valid && (sc_score != '0);
      cmd.shift_out = rsp_strobe;
      cmd.clear = done;
   end

   genvar i;
   generate
      for (i = 0; i < LIST_DEPTH; i++) begin : g_cell
         wmtk_pkg::score_type p_score, n_score;
         logic [ROW_NUMBER_BITS-1:0] p_row, n_row;
         logic p_gt;

         if (i == 0) begin : g_first
            assign p_score = '0;
            assign p_row = '0;
            assign p_gt = 1'b0;
         end else begin : g_inner
            assign p_score = cell_score[i-1];
            assign p_row = cell_row[i-1];
            assign p_gt = cell_gt[i-1];
         end

         if (i == LIST_DEPTH - 1) begin : g_last
            assign n_score = '0;
            assign n_row = '0;
         end else begin : g_more
            assign n_score = cell_score[i+1];
            assign n_row = cell_row[i+1];
         end

         wmtk_cell #(
            .ROW_NUMBER_BITS(ROW_NUMBER_BITS)
         ) u_cell (
            .clock(clock),
            .reset(reset),
            .cmd(cmd),
            .new_score(sc_score),
            .new_row(sc_row),
            .prev_score(p_score),
            .prev_row(p_row),
            .prev_gt(p_gt),
            .next_score(n_score),
            .next_row(n_row),
            .gt(cell_gt[i]),
            .score(cell_score[i]),
            .row(cell_row[i])
         );
      end

      if (LIST_DEPTH > 1) begin : g_second
         assign second_score = cell_score[1];
      end else begin : g_single
         assign second_score = '0;
      end
   endgenerate

   assign rsp_row_number = wmtk_pkg::OUT_ROW_BITS'(cell_row[0]);
   assign rsp_score_halves = cell_score[0];
   assign rsp_last_result = (emitted_ff + 5'd1 == keep_count_ff) || (second_score == '0);

   always_comb begin
      busy_in = busy_ff;
      emit_in = emit_ff;
      emitted_in = emitted_ff;
      rows_seen_in = rows_seen_ff;
      if (accept) begin
         busy_in = req_final_row;
         rows_seen_in = req_final_row ? '0 : rows_seen_ff + 1'b1;
      end
      if (sc_valid && sc_final) begin
         emit_in = 1'b1;
      end
      if (rsp_strobe) begin
         emitted_in = emitted_ff + 5'd1;
      end
      if (done) begin
         busy_in = 1'b0;
         emit_in = 1'b0;
         emitted_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         emit_ff <= 1'b0;
         emitted_ff <= '0;
         rows_seen_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         emit_ff <= emit_in;
         emitted_ff <= emitted_in;
         rows_seen_ff <= rows_seen_in;
      end
   end

endmodule

`default_nettype wire

>>> bench/testbench.sv
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import wmtk_pkg::*;

   localparam int DEPTH = 16;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES = 8;
   localparam int MAX_GAP = 20;
   localparam logic signed [31:0] ANCHOR_LAT = 32'sd169869312;
   localparam logic signed [31:0] ANCHOR_LON = -32'sd310378496;

   typedef struct packed {
      logic [OUT_ROW_BITS-1:0] row_number;
      score_type score;
      logic last;
   } report_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   wire busy;
   logic signed [CODE_BITS-1:0] req_row_region = '0;
   logic signed [CODE_BITS-1:0] req_row_category = '0;
   logic signed [COORD_BITS-1:0] req_row_latitude = '0;
   logic signed [COORD_BITS-1:0] req_row_longitude = '0;
   logic req_final_row = 1'b0;
   wire rsp_strobe;
   wire [OUT_ROW_BITS-1:0] rsp_row_number;
   wire [SCORE_BITS-1:0] rsp_score_halves;
   wire rsp_last_result;
   logic csr_write_enable = 1'b0;
   csr_index_type csr_index = CSR_QUERY_REGION;
   logic [CSR_DATA_BITS-1:0] csr_write_data = '0;

   logic [QUERY_CODE_BITS-1:0] q_region;
   logic [QUERY_CODE_BITS-1:0] q_category;
   logic signed [COORD_BITS-1:0] q_lat;
   logic signed [COORD_BITS-1:0] q_lon;
   logic [KEEP_BITS-1:0] q_keep;
   score_type list_score [DEPTH];
   logic [OUT_ROW_BITS-1:0] list_row [DEPTH];
   int held;
   logic [OUT_ROW_BITS-1:0] row_count;
   report_type pending_reports [$];
   int mismatches = 0;
   int idle_pct = 0;
   int quiet_cycles = 0;

   weighted_match_top_k_core #(
      .LIST_DEPTH(DEPTH),
      .ROW_NUMBER_BITS(32)
   ) uut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_row_region(req_row_region),
      .req_row_category(req_row_category),
      .req_row_latitude(req_row_latitude),
      .req_row_longitude(req_row_longitude),
      .req_final_row(req_final_row),
      .rsp_strobe(rsp_strobe),
      .rsp_row_number(rsp_row_number),
      .rsp_score_halves(rsp_score_halves),
      .rsp_last_result(rsp_last_result),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always #4 clock = ~clock;

   function automatic void clear_list();
      for (int i = 0; i < DEPTH; i++) begin
         list_score[i] = '0;
         list_row[i] = '0;
      end
      held = 0;
      row_count = '0;
   endfunction

   function automatic void apply_reg(csr_index_type idx, logic [CSR_DATA_BITS-1:0] data);
      case (idx)
         CSR_QUERY_REGION: q_region = data[QUERY_CODE_BITS-1:0];
         CSR_QUERY_CATEGORY: q_category = data[QUERY_CODE_BITS-1:0];
         CSR_QUERY_LATITUDE: q_lat = data;
         CSR_QUERY_LONGITUDE: q_lon = data;
         CSR_KEEP_COUNT: q_keep = data[KEEP_BITS-1:0];
         default: ;
      endcase
   endfunction

   // Squared coordinate difference in units of 2^-44 square degrees, saturating.
   function automatic logic [63:0] square_sat(logic signed [31:0] a, logic signed [31:0] b);
      logic signed [32:0] diff;
      logic [32:0] mag;
      diff = $signed({a[31], a}) - $signed({b[31], b});
      mag = diff[32] ? 33'(-diff) : 33'(diff);
      if (mag[32])
         return '1;
      return {32'b0, mag[31:0]} * {32'b0, mag[31:0]};
   endfunction

   function automatic score_type row_score(logic signed [7:0] region, logic signed [7:0] category,
                                           logic signed [31:0] lat, logic signed [31:0] lon);
      logic [64:0] total;
      logic [63:0] distance;
      score_type s;
      s = '0;
      if (q_region != 0 && region == $signed({1'b0, q_region}))
         s += SCORE_REGION;
      if (q_category != 0 && category == $signed({1'b0, q_category}))
         s += SCORE_CATEGORY;
      if (q_lat != 0 && q_lon != 0 && lat != 0) begin
         total = {1'b0, square_sat(lat, q_lat)} + {1'b0, square_sat(lon, q_lon)};
         distance = total[64] ? '1 : total[63:0];
         if (distance <= NEAR_LIMIT)
            s += SCORE_NEAR;
         else if (distance <= MID_LIMIT)
            s += SCORE_MID;
      end
      return s;
   endfunction

   function automatic void insert_ranked(score_type s, logic [OUT_ROW_BITS-1:0] row);
      int pos;
      int j;
      pos = held;
      while (pos > 0 && list_score[pos-1] < s)
         pos--;
      if (pos >= DEPTH)
         return;
      j = (held < DEPTH) ? held : DEPTH - 1;
      while (j > pos) begin
         list_score[j] = list_score[j-1];
         list_row[j] = list_row[j-1];
         j--;
      end
      list_score[pos] = s;
      list_row[pos] = row;
      if (held < DEPTH)
         held++;
   endfunction

   function automatic void absorb_row(logic signed [7:0] region, logic signed [7:0] category,
                                      logic signed [31:0] lat, logic signed [31:0] lon,
                                      logic final_flag);
      score_type s;
      int keep_n;
      int n;
      report_type entry;
      s = row_score(region, category, lat, lon);
      if (s != 0)
         insert_ranked(s, row_count);
      row_count++;
      if (final_flag) begin
         keep_n = (q_keep < DEPTH) ? int'(q_keep) : DEPTH;
         n = (held < keep_n) ? held : keep_n;
         for (int k = 0; k < n; k++) begin
            entry.row_number = list_row[k];
            entry.score = list_score[k];
            entry.last = (k + 1 == n);
            pending_reports.insert(pending_reports.size(), entry);
         end
         clear_list();
      end
   endfunction

   task automatic program_query(input logic [6:0] region, input logic [6:0] category,
                                input logic [31:0] lat, input logic [31:0] lon,
                                input logic [4:0] keep);
      csr_index_type idx [5];
      logic [CSR_DATA_BITS-1:0] val [5];
      idx = '{CSR_QUERY_REGION, CSR_QUERY_CATEGORY, CSR_QUERY_LATITUDE,
              CSR_QUERY_LONGITUDE, CSR_KEEP_COUNT};
      val[0] = {25'($urandom), region};
      val[1] = {25'($urandom), category};
      val[2] = lat;
      val[3] = lon;
      val[4] = {27'($urandom), keep};
      for (int i = 0; i < 5; i++) begin
         csr_write_enable <= 1'b1;
         csr_index <= idx[i];
         csr_write_data <= val[i];
         @(posedge clock);
         apply_reg(idx[i], val[i]);
      end
      csr_write_enable <= 1'b0;
   endtask

   task automatic send_row(input logic signed [7:0] region, input logic signed [7:0] category,
                           input logic signed [31:0] lat, input logic signed [31:0] lon,
                           input logic final_flag);
      int gap;
      start <= 1'b1;
      req_row_region <= region;
      req_row_category <= category;
      req_row_latitude <= lat;
      req_row_longitude <= lon;
      req_final_row <= final_flag;
      do
         @(posedge clock);
      while (busy);
      absorb_row(region, category, lat, lon, final_flag);
      gap = 0;
      while (idle_pct > 0 && gap < MAX_GAP && $urandom_range(99) < idle_pct)
         gap++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Rows still being scored produce no result, so a fixed margin follows the drain.
   task automatic settle();
      start <= 1'b0;
      do
         @(posedge clock);
      while (pending_reports.size() != 0 || busy);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic test_idle_defaults();
      send_row(8'sd5, 8'sd9, 32'sd1000, 32'sd1000, 1'b0);
      send_row(8'sd0, 8'sd0, 32'sd0, 32'sd0, 1'b0);
      send_row(-8'sd1, 8'sd127, ANCHOR_LAT, ANCHOR_LON, 1'b1);
      settle();
   endtask

   task automatic test_scoring_rules();
      program_query(7'd127, 7'd1, ANCHOR_LAT, ANCHOR_LON, 5'd16);
      send_row(8'sd127, 8'sd0, 32'sd0, 32'sd0, 1'b0);
      send_row(-8'sd128, 8'sd1, 32'sd0, 32'sd0, 1'b0);
      send_row(8'sd127, 8'sd1, ANCHOR_LAT, ANCHOR_LON, 1'b0);
      send_row(-8'sd1, -8'sd127, ANCHOR_LAT, ANCHOR_LON, 1'b0);
      send_row(8'sd0, 8'sd0, ANCHOR_LAT + 132635, ANCHOR_LON, 1'b0);
      send_row(8'sd0, 8'sd0, ANCHOR_LAT + 132636, ANCHOR_LON, 1'b0);
      send_row(8'sd0, 8'sd0, ANCHOR_LAT, ANCHOR_LON - 419430, 1'b0);
      send_row(8'sd0, 8'sd0, ANCHOR_LAT, ANCHOR_LON - 419431, 1'b0);
      send_row(8'sd127, 8'sd1, 32'sd0, ANCHOR_LON, 1'b0);
      send_row(8'sd126, 8'sd2, 32'h7FFFFFFF, 32'h80000000, 1'b0);
      send_row(8'sd127, 8'sd1, ANCHOR_LAT, ANCHOR_LON, 1'b1);
      settle();
   endtask

   task automatic test_wide_query();
      program_query(7'd0, 7'd127, 32'h80000000, 32'h7FFFFFFF, 5'd31);
      send_row(8'sd0, 8'sd127, 32'h7FFFFFFF, 32'h80000000, 1'b0);
      send_row(8'sd127, -8'sd128, 32'h80000000, 32'h7FFFFFFF, 1'b0);
      send_row(8'sd0, 8'sd127, 32'h80000001, 32'h7FFFFFFE, 1'b0);
      send_row(8'sd0, 8'sd0, 32'sd0, 32'h7FFFFFFF, 1'b1);
      settle();
   endtask

   task automatic test_quiet_reports();
      program_query(7'd127, 7'd127, 32'sd0, 32'sd0, 5'd0);
      send_row(8'sd127, 8'sd127, ANCHOR_LAT, ANCHOR_LON, 1'b0);
      send_row(8'sd127, 8'sd0, ANCHOR_LAT, ANCHOR_LON, 1'b1);
      settle();
      program_query(7'd0, 7'd0, ANCHOR_LAT, 32'sd0, 5'd5);
      send_row(8'sd0, 8'sd0, ANCHOR_LAT, ANCHOR_LON, 1'b0);
      send_row(8'sd0, 8'sd0, ANCHOR_LAT, 32'sd0, 1'b1);
      settle();
   endtask

   task automatic program_random_query();
      logic [6:0] region;
      logic [6:0] category;
      logic [31:0] lat;
      logic [31:0] lon;
      logic [4:0] keep;
      region = ($urandom_range(9) == 0) ? 7'd0 : 7'($urandom_range(1, 127));
      category = ($urandom_range(9) == 0) ? 7'd0 : 7'($urandom_range(1, 127));
      lat = ($urandom_range(7) == 0) ? 32'd0 : $urandom;
      lon = ($urandom_range(7) == 0) ? 32'd0 : $urandom;
      case ($urandom_range(9))
         0: keep = 5'd0;
         1: keep = 5'd31;
         2, 3: keep = 5'd16;
         4: keep = 5'd1;
         default: keep = 5'($urandom_range(1, 31));
      endcase
      program_query(region, category, lat, lon, keep);
   endtask

   task automatic test_random_sets(input int row_budget, input int pct);
      int sent;
      int len;
      int offset;
      logic signed [7:0] region;
      logic signed [7:0] category;
      logic signed [31:0] lat;
      logic signed [31:0] lon;
      sent = 0;
      while (sent < row_budget) begin
         if ($urandom_range(99) < 60) begin
            settle();
            program_random_query();
         end
         idle_pct = ($urandom_range(3) == 0) ? 0 : pct;
         len = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
         for (int i = 0; i < len; i++) begin
            region = $urandom_range(1) ? $signed({1'b0, q_region}) : 8'($urandom);
            category = ($urandom_range(4) < 2) ? $signed({1'b0, q_category}) : 8'($urandom);
            offset = $urandom_range(1200000) - 600000;
            case ($urandom_range(9))
               0: lat = '0;
               1, 2: lat = $urandom;
               default: lat = q_lat + offset;
            endcase
            offset = $urandom_range(1200000) - 600000;
            lon = ($urandom_range(4) == 0) ? 32'($urandom) : q_lon + offset;
            send_row(region, category, lat, lon, i == len - 1);
            sent++;
         end
      end
      settle();
      idle_pct = 0;
   endtask

   always @(posedge clock) begin : check_reports
      report_type want;
      if (!reset && rsp_strobe) begin
         if (pending_reports.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: row %0d score %0d last %0b",
                        rsp_row_number, rsp_score_halves, rsp_last_result);
         end else begin
            want = pending_reports.pop_front();
            if (want.row_number !== rsp_row_number || want.score !== rsp_score_halves ||
                want.last !== rsp_last_result) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $write("result mismatch: expected row %0d score %0d last %0b,",
                         want.row_number, want.score, want.last);
                  $display(" got row %0d score %0d last %0b",
                           rsp_row_number, rsp_score_halves, rsp_last_result);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || csr_write_enable)
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      q_region = '0;
      q_category = '0;
      q_lat = '0;
      q_lon = '0;
      q_keep = KEEP_COUNT_RESET;
      clear_list();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_idle_defaults();
      test_scoring_rules();
      test_wide_query();
      test_quiet_reports();
      test_random_sets(145, 35);
      test_random_sets(145, 62);
      test_random_sets(145, 0);
      repeat (10) @(posedge clock);
      if (mismatches == 0 && pending_reports.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

`default_nettype wire

>>> files.f
rtl/wmtk_pkg.sv
rtl/wmtk_score.sv
rtl/wmtk_cell.sv
rtl/weighted_match_top_k_core.sv
bench/testbench.sv
